// File: hw/rtl/qrs_pkg.sv
`default_nettype none

package qrs_pkg;

    // Result case codes
    localparam logic [1:0] CASE_NONE = 2'd0;
    localparam logic [1:0] CASE_ONE  = 2'd1;
    localparam logic [1:0] CASE_TWO  = 2'd2;
    localparam logic [1:0] CASE_INF  = 2'd3;

    // Per-request control decided ahead of the root and divide pipelines
    typedef struct packed {
        logic [1:0] kase;     // final case code
        logic       lin;      // linear equation: root is -c/b
        logic       neg_lin;  // sign of -c/b
        logic       sa;       // sign of a
        logic       sb;       // sign of b
    } t_ctrl;

endpackage

`default_nettype wire

// File: hw/rtl/qrs_front.sv
`default_nettype none

module qrs_front #(
    parameter int W = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic signed [W-1:0]   i_coef_quad,
    input  wire logic signed [W-1:0]   i_coef_lin,
    input  wire logic signed [W-1:0]   i_coef_const,
    output logic                       o_valid,
    output logic [2*W:0]               o_rad,
    output qrs_pkg::t_ctrl             o_ctrl,
    output logic [W-1:0]               o_ma,
    output logic [W-1:0]               o_mb,
    output logic [W-1:0]               o_mc
);

    localparam int LO  = W / 2;
    localparam int HI  = W - LO;
    localparam int PW2 = 2 * W;
    localparam int DW  = 2 * W + 1;

    // Stage 0: sign and magnitude
    logic         r0_v;
    logic         r0_sa, r0_sb, r0_sc;
    logic [W-1:0] r0_ma, r0_mb, r0_mc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else begin
            r0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_sa <= i_coef_quad[W-1];
        r0_sb <= i_coef_lin[W-1];
        r0_sc <= i_coef_const[W-1];
        r0_ma <= i_coef_quad[W-1]  ? (~$unsigned(i_coef_quad) + 1'b1)  : $unsigned(i_coef_quad);
        r0_mb <= i_coef_lin[W-1]   ? (~$unsigned(i_coef_lin) + 1'b1)   : $unsigned(i_coef_lin);
        r0_mc <= i_coef_const[W-1] ? (~$unsigned(i_coef_const) + 1'b1) : $unsigned(i_coef_const);
    end

    // Stage 1: half-width partial products, zero flags
    logic                r1_v;
    logic                r1_sa, r1_sb, r1_sc, r1_za, r1_zb, r1_zc;
    logic [W-1:0]        r1_ma, r1_mb, r1_mc;
    logic [2*HI-1:0]     r1_bb_hh, r1_ac_hh;
    logic [HI+LO-1:0]    r1_bb_hl, r1_ac_hl, r1_ac_lh;
    logic [2*LO-1:0]     r1_bb_ll, r1_ac_ll;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= r0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_sa    <= r0_sa;
        r1_sb    <= r0_sb;
        r1_sc    <= r0_sc;
        r1_za    <= (r0_ma == '0);
        r1_zb    <= (r0_mb == '0);
        r1_zc    <= (r0_mc == '0);
        r1_ma    <= r0_ma;
        r1_mb    <= r0_mb;
        r1_mc    <= r0_mc;
        r1_bb_hh <= r0_mb[W-1:LO] * r0_mb[W-1:LO];
        r1_bb_hl <= r0_mb[W-1:LO] * r0_mb[LO-1:0];
        r1_bb_ll <= r0_mb[LO-1:0] * r0_mb[LO-1:0];
        r1_ac_hh <= r0_ma[W-1:LO] * r0_mc[W-1:LO];
        r1_ac_hl <= r0_ma[W-1:LO] * r0_mc[LO-1:0];
        r1_ac_lh <= r0_ma[LO-1:0] * r0_mc[W-1:LO];
        r1_ac_ll <= r0_ma[LO-1:0] * r0_mc[LO-1:0];
    end

    // Stage 2: sum partial products into b*b and a*c
    logic           r2_v;
    logic           r2_sa, r2_sb, r2_sc, r2_za, r2_zb, r2_zc;
    logic [W-1:0]   r2_ma, r2_mb, r2_mc;
    logic [PW2-1:0] r2_bb, r2_ac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_sa <= r1_sa;
        r2_sb <= r1_sb;
        r2_sc <= r1_sc;
        r2_za <= r1_za;
        r2_zb <= r1_zb;
        r2_zc <= r1_zc;
        r2_ma <= r1_ma;
        r2_mb <= r1_mb;
        r2_mc <= r1_mc;
        r2_bb <= (PW2'(r1_bb_hh) << (2 * LO)) + (PW2'(r1_bb_hl) << (LO + 1))
               + PW2'(r1_bb_ll);
        r2_ac <= (PW2'(r1_ac_hh) << (2 * LO)) + (PW2'(r1_ac_hl) << LO)
               + (PW2'(r1_ac_lh) << LO) + PW2'(r1_ac_ll);
    end

    // Stage 3: discriminant and case decision
    logic           r3_v;
    logic [DW-1:0]  r3_d;
    qrs_pkg::t_ctrl r3_ctrl;
    logic [W-1:0]   r3_ma, r3_mb, r3_mc;

    logic [DW-1:0]  bbx, ac4, d_sum, d_dif, n_d;
    logic           d_neg;
    qrs_pkg::t_ctrl n_ctrl;

    always_comb begin
        bbx   = DW'(r2_bb);
        ac4   = {r2_ac[PW2-2:0], 2'b00};
        d_sum = bbx + ac4;
        d_dif = bbx - ac4;
        d_neg = (r2_sa == r2_sc) && (bbx < ac4);
        n_d   = (r2_sa != r2_sc) ? d_sum : (d_neg ? '0 : d_dif);

        n_ctrl.sa      = r2_sa;
        n_ctrl.sb      = r2_sb;
        n_ctrl.lin     = r2_za && !r2_zb;
        n_ctrl.neg_lin = !r2_sc ^ r2_sb;
        if (r2_za) begin
            if (r2_zb) begin
                n_ctrl.kase = r2_zc ? qrs_pkg::CASE_INF : qrs_pkg::CASE_NONE;
            end else begin
                n_ctrl.kase = qrs_pkg::CASE_ONE;
            end
        end else if (d_neg) begin
            n_ctrl.kase = qrs_pkg::CASE_NONE;
        end else if (n_d == '0) begin
            n_ctrl.kase = qrs_pkg::CASE_ONE;
        end else begin
            n_ctrl.kase = qrs_pkg::CASE_TWO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_d    <= n_d;
        r3_ctrl <= n_ctrl;
        r3_ma   <= r2_ma;
        r3_mb   <= r2_mb;
        r3_mc   <= r2_mc;
    end

    assign o_valid = r3_v;
    assign o_rad   = r3_d;
    assign o_ctrl  = r3_ctrl;
    assign o_ma    = r3_ma;
    assign o_mb    = r3_mb;
    assign o_mc    = r3_mc;

endmodule

`default_nettype wire

// File: hw/rtl/qrs_sqrt.sv
`default_nettype none

module qrs_sqrt #(
    parameter int RAD_W  = 65,
    parameter int SIDE_W = 8
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire logic [RAD_W-1:0]          i_rad,
    input  wire logic [SIDE_W-1:0]         i_side,
    output logic                           o_valid,
    output logic [(RAD_W+1)/2-1:0]         o_root,
    output logic [SIDE_W-1:0]              o_side
);

    localparam int SW = (RAD_W + 1) / 2;
    localparam int PW = 2 * SW;
    localparam int RW = SW + 3;

    // Stage inputs and stage registers, one result bit per stage
    logic [PW-1:0]     s_rad  [SW];
    logic [RW-1:0]     s_rem  [SW];
    logic [SW-1:0]     s_root [SW];
    logic [SIDE_W-1:0] s_side [SW];
    logic              s_v    [SW];

    logic [PW-1:0]     r_rad  [SW];
    logic [RW-1:0]     r_rem  [SW];
    logic [SW-1:0]     r_root [SW];
    logic [SIDE_W-1:0] r_side [SW];
    logic              r_v    [SW];

    genvar k;
    for (k = 0; k < SW; k++) begin : g_stage
        logic [RW-1:0] cur, trial;
        logic          ge;

        if (k == 0) begin : g_first
            // Zero-extend to an even width so bit pairs stay aligned
            assign s_rad[k]  = PW'(i_rad);
            assign s_rem[k]  = '0;
            assign s_root[k] = '0;
            assign s_side[k] = i_side;
            assign s_v[k]    = i_valid;
        end else begin : g_next
            assign s_rad[k]  = r_rad[k-1];
            assign s_rem[k]  = r_rem[k-1];
            assign s_root[k] = r_root[k-1];
            assign s_side[k] = r_side[k-1];
            assign s_v[k]    = r_v[k-1];
        end

        // Bring down two radicand bits, try 4*root+1
        assign cur   = {s_rem[k][RW-3:0], s_rad[k][PW-1:PW-2]};
        assign trial = {1'b0, s_root[k], 2'b01};
        assign ge    = (cur >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= s_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rad[k]  <= s_rad[k] << 2;
            r_rem[k]  <= ge ? (cur - trial) : cur;
            r_root[k] <= {s_root[k][SW-2:0], ge};
            r_side[k] <= s_side[k];
        end
    end

    assign o_valid = r_v[SW-1];
    assign o_root  = r_root[SW-1];
    assign o_side  = r_side[SW-1];

endmodule

`default_nettype wire

// File: hw/rtl/qrs_div.sv
`default_nettype none

module qrs_div #(
    parameter int NUM_W  = 33,
    parameter int DEN_W  = 33,
    parameter int FRAC   = 16,
    parameter int SIDE_W = 1
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    input  wire logic [NUM_W-1:0]        i_num,
    input  wire logic [DEN_W-1:0]        i_den,
    input  wire logic [SIDE_W-1:0]       i_side,
    output logic                         o_valid,
    output logic [NUM_W+FRAC-1:0]        o_quot,
    output logic [SIDE_W-1:0]            o_side
);

    localparam int QW = NUM_W + FRAC;

    // Restoring division, one quotient bit per stage
    logic [QW-1:0]     s_num  [QW];
    logic [DEN_W-1:0]  s_rem  [QW];
    logic [QW-1:0]     s_q    [QW];
    logic [DEN_W-1:0]  s_den  [QW];
    logic [SIDE_W-1:0] s_side [QW];
    logic              s_v    [QW];

    logic [QW-1:0]     r_num  [QW];
    logic [DEN_W-1:0]  r_rem  [QW];
    logic [QW-1:0]     r_q    [QW];
    logic [DEN_W-1:0]  r_den  [QW];
    logic [SIDE_W-1:0] r_side [QW];
    logic              r_v    [QW];

    genvar k;
    for (k = 0; k < QW; k++) begin : g_stage
        logic [DEN_W:0] cur, sub;
        logic           ge;

        if (k == 0) begin : g_first
            assign s_num[k]  = QW'(i_num) << FRAC;
            assign s_rem[k]  = '0;
            assign s_q[k]    = '0;
            assign s_den[k]  = i_den;
            assign s_side[k] = i_side;
            assign s_v[k]    = i_valid;
        end else begin : g_next
            assign s_num[k]  = r_num[k-1];
            assign s_rem[k]  = r_rem[k-1];
            assign s_q[k]    = r_q[k-1];
            assign s_den[k]  = r_den[k-1];
            assign s_side[k] = r_side[k-1];
            assign s_v[k]    = r_v[k-1];
        end

        // Shift in the next dividend bit and subtract if it fits
        assign cur = {s_rem[k], s_num[k][QW-1]};
        assign ge  = (cur >= {1'b0, s_den[k]});
        assign sub = cur - {1'b0, s_den[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= s_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_num[k]  <= s_num[k] << 1;
            r_rem[k]  <= ge ? sub[DEN_W-1:0] : cur[DEN_W-1:0];
            r_q[k]    <= {s_q[k][QW-2:0], ge};
            r_den[k]  <= s_den[k];
            r_side[k] <= s_side[k];
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_quot  = r_q[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

`default_nettype wire

// File: hw/rtl/quadratic_root_solver.sv
// Fixed-point quadratic solver. A request (a, b, c) is taken whenever start is
// high; busy never rises, so one request may enter every clock. Each request
// gives exactly one result, shown for a single cycle with o_valid high, in
// request order. A request passes the front end, the square-root pipeline (one
// root bit per stage), the numerator register, the divider lanes (one quotient
// bit per stage) and the output register; roots are Q16.16 with the default
// parameters. The receiver must take every result as it appears.
`default_nettype none

module quadratic_root_solver #(
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic signed [COEF_WIDTH-1:0] i_coef_quad,
    input  wire logic signed [COEF_WIDTH-1:0] i_coef_lin,
    input  wire logic signed [COEF_WIDTH-1:0] i_coef_const,
    output logic                              o_valid,
    output logic [1:0]                        o_root_case,
    output logic signed [COEF_WIDTH-1:0]      o_root_first,
    output logic signed [COEF_WIDTH-1:0]      o_root_second,
    output logic                              o_saturated
);

    localparam int W      = COEF_WIDTH;
    localparam int DW     = 2 * W + 1;
    localparam int SW     = W + 1;
    localparam int NBW    = W + 3;
    localparam int QW     = W + 1 + FRAC_BITS;
    localparam int CTRL_W = $bits(qrs_pkg::t_ctrl);
    localparam int SIDE_W = CTRL_W + 3 * W;

    // Never stall: every stage advances each cycle
    assign busy = 1'b0;

    // Front end: decode, products, discriminant
    logic           fe_v;
    logic [DW-1:0]  fe_rad;
    qrs_pkg::t_ctrl fe_ctrl;
    logic [W-1:0]   fe_ma, fe_mb, fe_mc;

    qrs_front #(
        .W (W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (start),
        .i_coef_quad  (i_coef_quad),
        .i_coef_lin   (i_coef_lin),
        .i_coef_const (i_coef_const),
        .o_valid      (fe_v),
        .o_rad        (fe_rad),
        .o_ctrl       (fe_ctrl),
        .o_ma         (fe_ma),
        .o_mb         (fe_mb),
        .o_mc         (fe_mc)
    );

    // Square root of the discriminant
    logic              sq_v;
    logic [SW-1:0]     sq_root;
    logic [SIDE_W-1:0] sq_side;

    qrs_sqrt #(
        .RAD_W  (DW),
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fe_v),
        .i_rad   (fe_rad),
        .i_side  ({fe_ctrl, fe_ma, fe_mb, fe_mc}),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // Numerators and divisor
    qrs_pkg::t_ctrl    sq_ctrl;
    logic [W-1:0]      sq_ma, sq_mb, sq_mc;
    logic signed [NBW-1:0] nb, sv, n1, n2, a1, a2;
    logic [W:0]        n_num1, n_num2, n_den;
    logic              n_neg1, n_neg2;

    always_comb begin
        sq_ctrl = qrs_pkg::t_ctrl'(sq_side[SIDE_W-1 -: CTRL_W]);
        sq_ma   = sq_side[3*W-1 -: W];
        sq_mb   = sq_side[2*W-1 -: W];
        sq_mc   = sq_side[W-1:0];
        nb      = sq_ctrl.sb ? $signed({3'b000, sq_mb}) : -$signed({3'b000, sq_mb});
        sv      = $signed({2'b00, sq_root});
        n1      = nb - sv;
        n2      = nb + sv;
        a1      = n1[NBW-1] ? -n1 : n1;
        a2      = n2[NBW-1] ? -n2 : n2;
        if (sq_ctrl.lin) begin
            n_num1 = {1'b0, sq_mc};
            n_den  = {1'b0, sq_mb};
            n_neg1 = sq_ctrl.neg_lin;
        end else begin
            n_num1 = a1[W:0];
            n_den  = {sq_ma, 1'b0};
            n_neg1 = n1[NBW-1] ^ sq_ctrl.sa;
        end
        n_num2 = a2[W:0];
        n_neg2 = n2[NBW-1] ^ sq_ctrl.sa;
    end

    logic       r_nm_v;
    logic [W:0] r_num1, r_num2, r_den;
    logic       r_neg1, r_neg2;
    logic [1:0] r_nm_case;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nm_v <= 1'b0;
        end else begin
            r_nm_v <= sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num1    <= n_num1;
        r_num2    <= n_num2;
        r_den     <= n_den;
        r_neg1    <= n_neg1;
        r_neg2    <= n_neg2;
        r_nm_case <= sq_ctrl.kase;
    end

    // Two divider lanes, one per root
    logic          d1_v, d2_v;
    logic [QW-1:0] d1_q, d2_q;
    logic [2:0]    d1_side;
    logic          d2_neg;

    qrs_div #(
        .NUM_W  (W + 1),
        .DEN_W  (W + 1),
        .FRAC   (FRAC_BITS),
        .SIDE_W (3)
    ) u_div_first (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_nm_v),
        .i_num   (r_num1),
        .i_den   (r_den),
        .i_side  ({r_neg1, r_nm_case}),
        .o_valid (d1_v),
        .o_quot  (d1_q),
        .o_side  (d1_side)
    );

    qrs_div #(
        .NUM_W  (W + 1),
        .DEN_W  (W + 1),
        .FRAC   (FRAC_BITS),
        .SIDE_W (1)
    ) u_div_second (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_nm_v),
        .i_num   (r_num2),
        .i_den   (r_den),
        .i_side  (r_neg2),
        .o_valid (d2_v),
        .o_quot  (d2_q),
        .o_side  (d2_neg)
    );

    // Clamp a quotient magnitude to the signed range and apply the sign
    function automatic logic [W:0] clamp(input logic neg, input logic [QW-1:0] q);
        logic [QW-1:0] lim;
        logic [W-1:0]  mag;
        logic          sat;
        lim = neg ? (QW'(1) << (W - 1)) : ((QW'(1) << (W - 1)) - 1'b1);
        sat = (q > lim);
        mag = sat ? lim[W-1:0] : q[W-1:0];
        return {sat, (neg ? (~mag + 1'b1) : mag)};
    endfunction

    logic [1:0] d_case;
    logic [W:0] c1, c2;
    logic       has1, has2;

    always_comb begin
        d_case = d1_side[1:0];
        c1     = clamp(d1_side[2], d1_q);
        c2     = clamp(d2_neg, d2_q);
        has1   = (d_case == qrs_pkg::CASE_ONE) || (d_case == qrs_pkg::CASE_TWO);
        has2   = (d_case == qrs_pkg::CASE_TWO);
    end

    // Output register
    logic         r_out_v;
    logic [1:0]   r_case;
    logic [W-1:0] r_first, r_second;
    logic         r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= d1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_case   <= d_case;
        r_first  <= has1 ? c1[W-1:0] : '0;
        r_second <= has2 ? c2[W-1:0] : '0;
        r_sat    <= (has1 && c1[W]) || (has2 && c2[W]);
    end

    assign o_valid       = r_out_v;
    assign o_root_case   = r_case;
    assign o_root_first  = $signed(r_first);
    assign o_root_second = $signed(r_second);
    assign o_saturated   = r_sat;

    // Both divider lanes carry the same request
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d1_v == d2_v)
        else $error("divider lanes out of step");

    // A second root only with two roots
    a_second_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_root_case != qrs_pkg::CASE_TWO) |-> (o_root_second == '0))
        else $error("second root set without two roots");

    // Saturation only where a root was produced
    a_sat_case: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |->
            (o_root_case == qrs_pkg::CASE_ONE) || (o_root_case == qrs_pkg::CASE_TWO))
        else $error("saturation flagged without a root");

    // A request leaving the numerator register reaches the output through the divider lanes and output register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nm_v |=> ##(QW) o_valid)
        else $error("result lost in divider pipeline");

endmodule

`default_nettype wire
